@@ design/wsq_pkg.sv @@
// Package with types, constants and the wrap-around compare of the sorted queue.
package wsq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W = 6;
  localparam int REC_W = 80;
  localparam logic [31:0] MAX_SEQ_RESET = 32'd65535;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sequence_req;
    logic [31:0] arrival_time;
    logic [15:0] packet_size;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        accepted;
    logic        dropped_full;
    logic        dropped_duplicate;
    logic        pop_valid;
    logic [31:0] pop_sequence;
    logic [31:0] pop_time;
    logic [15:0] pop_size;
    logic [5:0]  occupancy;
  } resp_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] tim;
    logic [15:0] size;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_DONE
  } state_t;

  function automatic logic newer(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] half);
    logic res;
    res = 1'b0;
    if (a > b) begin
      res = (a - b) <= half;
    end else if (b > a) begin
      res = (b - a) > half;
    end
    return res;
  endfunction

endpackage

@@ design/wsq_ram.sv @@
// Generic single-port RAM with registered read.
module wsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/wrapping_sequence_sorted_queue.sv @@
// Top level of the wrap-around sequence sorted packet queue.
//
// The records live in one RAM, oldest at address 0. Each command starts on
// start while busy is low and gives one result strobe. A query or insert
// first scans the stored records with one read per cycle. An accepted insert
// then shifts the tail up one entry at a time, and a pop shifts every record
// down the same way. Busy is shortest for a pop of an empty queue or an unused
// code and longest for an insert at the front, all set by the single RAM port,
// and the result strobe comes in the same cycle as busy falls. The result
// stands one cycle with done high and cannot be held off. The maximum sequence
// register is written on cfg_valid.
module wrapping_sequence_sorted_queue
  import wsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output resp_t       resp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  state_t           state, state_next;
  logic [31:0]      max_seq;
  req_t             cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos;
  logic             pos_set;
  logic             dup;
  logic [31:0]      first_seq;
  logic [31:0]      last_seq;
  logic             rd_pend;
  logic [CNT_W-1:0] rd_idx;
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  rec_t             ram_wdata, ram_rdata;
  logic [31:0]      half;
  logic             hit_newer;

  assign half = {1'b0, max_seq[31:1]};
  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  wsq_ram #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign hit_newer = newer(ram_rdata.seq, cur.sequence_req, half);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      max_seq <= MAX_SEQ_RESET;
      count <= '0;
      done <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      rd_pend <= (state == ST_SCAN) && (idx < count);
      if (cfg_valid) begin
        max_seq <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur <= req;
            idx <= (req.op == OP_POP && count != '0) ? CNT_W'(1) : '0;
            pos_set <= 1'b0;
            dup <= 1'b0;
            resp <= '0;
          end
        end
        ST_SCAN: begin
          if (idx < count) begin
            rd_idx <= idx;
            idx <= idx + CNT_W'(1);
          end
          if (rd_pend) begin
            if (rd_idx == '0) begin
              first_seq <= ram_rdata.seq;
            end
            if (rd_idx == count - CNT_W'(1)) begin
              last_seq <= ram_rdata.seq;
            end
            if (ram_rdata.seq == cur.sequence_req) begin
              dup <= 1'b1;
            end
            if (!pos_set && hit_newer) begin
              pos_set <= 1'b1;
              pos <= rd_idx;
            end
          end
        end
        ST_SHIFT_RD: begin
          if (cur.op == OP_INSERT) begin
            idx <= idx - CNT_W'(1);
          end
        end
        ST_SHIFT_WR: begin
          if (cur.op == OP_POP) begin
            if (idx == CNT_W'(1)) begin
              resp.pop_valid <= 1'b1;
              resp.pop_sequence <= ram_rdata.seq;
              resp.pop_time <= ram_rdata.tim;
              resp.pop_size <= ram_rdata.size;
            end
            idx <= idx + CNT_W'(1);
          end
        end
        ST_PUT: begin
          count <= count + CNT_W'(1);
          resp.accepted <= 1'b1;
        end
        default: ;
      endcase
      if (state == ST_SCAN && state_next != ST_SCAN) begin
        if (cur.op == OP_QUERY) begin
          resp.found <= dup;
        end else if (dup) begin
          resp.dropped_duplicate <= 1'b1;
        end else if (count >= CNT_W'(QUEUE_DEPTH)) begin
          resp.dropped_full <= 1'b1;
        end else begin
          idx <= count;
          if (count == '0 || !newer(cur.sequence_req, first_seq, half)) begin
            pos <= '0;
          end else if (newer(cur.sequence_req, last_seq, half) || !pos_set) begin
            pos <= count;
          end
        end
      end
      if (state == ST_SHIFT_RD && cur.op == OP_POP && idx > count) begin
        count <= count - CNT_W'(1);
      end
      if (state == ST_DONE) begin
        resp.occupancy <= OCC_W'(count);
      end
    end
  end

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_addr = '0;
    ram_wdata = '0;
    unique case (state)
      ST_IDLE: begin
        ram_addr = '0;
        if (start) begin
          unique case (req.op) inside
            OP_INSERT, OP_QUERY: state_next = ST_SCAN;
            OP_POP: state_next = (count != '0) ? ST_SHIFT_WR : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        ram_addr = IDX_W'(idx);
        if (idx >= count && !rd_pend) begin
          state_next = ST_DONE;
        end else if (idx >= count && rd_pend) begin
          state_next = ST_SCAN;
        end
        if (idx >= count && rd_pend) begin
          state_next = ST_SCAN;
        end
        if (idx >= count && !rd_pend) begin
          if (cur.op == OP_INSERT && !dup && count < CNT_W'(QUEUE_DEPTH)) begin
            state_next = ST_SHIFT_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SHIFT_RD: begin
        if (cur.op == OP_INSERT) begin
          if (idx > pos) begin
            ram_addr = IDX_W'(idx - CNT_W'(1));
            state_next = ST_SHIFT_WR;
          end else begin
            state_next = ST_PUT;
          end
        end else begin
          if (idx <= count) begin
            ram_addr = IDX_W'(idx - CNT_W'(1));
            state_next = ST_SHIFT_WR;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SHIFT_WR: begin
        if (cur.op == OP_INSERT) begin
          ram_we = 1'b1;
          ram_addr = IDX_W'(idx + CNT_W'(1));
          ram_wdata = ram_rdata;
        end else if (idx != CNT_W'(1)) begin
          ram_we = 1'b1;
          ram_addr = IDX_W'(idx - CNT_W'(2));
          ram_wdata = ram_rdata;
        end
        state_next = ST_SHIFT_RD;
      end
      ST_PUT: begin
        ram_we = 1'b1;
        ram_addr = IDX_W'(pos);
        ram_wdata.seq = cur.sequence_req;
        ram_wdata.tim = cur.arrival_time;
        ram_wdata.size = cur.packet_size;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ dv/tb_wrapping_sequence_sorted_queue.sv @@
// Self-checking testbench of the wrap-around sequence sorted packet queue.
`timescale 1ns / 1ps

module tb_wrapping_sequence_sorted_queue;
  import wsq_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  resp_t       resp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  wrapping_sequence_sorted_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .resp(resp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  typedef struct {
    req_t  cmd;
    logic  typed;
    resp_t want;
  } row_t;

  logic [31:0] q_seq[$];
  logic [31:0] q_tim[$];
  logic [15:0] q_size[$];
  logic [31:0] window_max;
  resp_t       pending[$];
  int          errors;
  logic        no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic is_newer(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] half;
    half = window_max >> 1;
    if (a > b) return (a - b) <= half;
    if (b > a) return (b - a) > half;
    return 1'b0;
  endfunction

  function automatic logic holds_seq(input logic [31:0] s);
    foreach (q_seq[i]) if (q_seq[i] == s) return 1'b1;
    return 1'b0;
  endfunction

  function automatic resp_t queue_step(input req_t r);
    resp_t o;
    int    pos;
    o = '0;
    case (op_t'(r.op))
      OP_INSERT: begin
        if (holds_seq(r.sequence_req)) begin
          o.dropped_duplicate = 1'b1;
        end else if (q_seq.size() >= QUEUE_DEPTH) begin
          o.dropped_full = 1'b1;
        end else begin
          if (q_seq.size() == 0 || !is_newer(r.sequence_req, q_seq[0])) begin
            pos = 0;
          end else if (is_newer(r.sequence_req, q_seq[q_seq.size() - 1])) begin
            pos = q_seq.size();
          end else begin
            pos = q_seq.size();
            for (int i = 0; i < q_seq.size(); i++) begin
              if (is_newer(q_seq[i], r.sequence_req)) begin
                pos = i;
                break;
              end
            end
          end
          q_seq.insert(pos, r.sequence_req);
          q_tim.insert(pos, r.arrival_time);
          q_size.insert(pos, r.packet_size);
          o.accepted = 1'b1;
        end
      end
      OP_QUERY: o.found = holds_seq(r.sequence_req);
      OP_POP: begin
        if (q_seq.size() > 0) begin
          o.pop_valid = 1'b1;
          o.pop_sequence = q_seq.pop_front();
          o.pop_time = q_tim.pop_front();
          o.pop_size = q_size.pop_front();
        end
      end
      default: ;
    endcase
    o.occupancy = 6'(q_seq.size());
    return o;
  endfunction

  always @(posedge clk) begin
    resp_t w;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        w = pending.pop_front();
        if (resp.found !== w.found) begin
          $error("found: expected %0d, got %0d", w.found, resp.found); errors++;
        end
        if (resp.accepted !== w.accepted) begin
          $error("accepted: expected %0d, got %0d", w.accepted, resp.accepted); errors++;
        end
        if (resp.dropped_full !== w.dropped_full) begin
          $error("dropped_full: expected %0d, got %0d", w.dropped_full,
                 resp.dropped_full);
          errors++;
        end
        if (resp.dropped_duplicate !== w.dropped_duplicate) begin
          $error("dropped_duplicate: expected %0d, got %0d", w.dropped_duplicate,
                 resp.dropped_duplicate);
          errors++;
        end
        if (resp.pop_valid !== w.pop_valid) begin
          $error("pop_valid: expected %0d, got %0d", w.pop_valid, resp.pop_valid); errors++;
        end
        if (resp.pop_sequence !== w.pop_sequence) begin
          $error("pop_sequence: expected %h, got %h", w.pop_sequence, resp.pop_sequence);
          errors++;
        end
        if (resp.pop_time !== w.pop_time) begin
          $error("pop_time: expected %h, got %h", w.pop_time, resp.pop_time); errors++;
        end
        if (resp.pop_size !== w.pop_size) begin
          $error("pop_size: expected %h, got %h", w.pop_size, resp.pop_size); errors++;
        end
        if (resp.occupancy !== w.occupancy) begin
          $error("occupancy: expected %0d, got %0d", w.occupancy, resp.occupancy); errors++;
        end
      end
    end
  end

  task automatic idle_burst();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Start one item; start is dropped only if the next item is not issued at once.
  task automatic issue(input req_t r, input logic typed, input resp_t want);
    resp_t p;
    req   <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = queue_step(r);
    if (typed && p !== want) begin
      $error("directed row: expected %h, predicted %h", want, p);
      errors++;
    end
    pending.insert(pending.size(), p);
    idle_burst();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(posedge clk);
    start <= 1'b0;
    while (pending.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3 * QUEUE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] v);
    drain();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    window_max = v;
    @(posedge clk);
  endtask

  function automatic req_t mk(input op_t o, input logic [31:0] s, input logic [31:0] t,
                              input logic [15:0] z);
    req_t r;
    r.op = o;
    r.sequence_req = s;
    r.arrival_time = t;
    r.packet_size = z;
    return r;
  endfunction

  function automatic resp_t rs(input logic [4:0] flags, input logic [31:0] s,
                               input logic [31:0] t, input logic [15:0] z,
                               input logic [5:0] occ);
    resp_t o;
    {o.found, o.accepted, o.dropped_full, o.dropped_duplicate, o.pop_valid} = flags;
    o.pop_sequence = s;
    o.pop_time = t;
    o.pop_size = z;
    o.occupancy = occ;
    return o;
  endfunction

  function automatic req_t rand_req(input logic [31:0] base, input logic [31:0] span);
    req_t r;
    int   k;
    k = $urandom_range(0, 99);
    r.op = k < 50 ? OP_INSERT : k < 70 ? OP_QUERY : k < 96 ? OP_POP : OP_NONE;
    if ($urandom_range(0, 9) == 0) r.sequence_req = $urandom;
    else r.sequence_req = base + $urandom_range(0, span);
    if (r.op == OP_QUERY && q_seq.size() > 0 && $urandom_range(0, 1))
      r.sequence_req = q_seq[$urandom_range(0, q_seq.size() - 1)];
    if (r.op == OP_INSERT && q_seq.size() > 0 && $urandom_range(0, 9) == 0)
      r.sequence_req = q_seq[$urandom_range(0, q_seq.size() - 1)];
    r.arrival_time = $urandom;
    r.packet_size = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  initial begin
    row_t        rows[$];
    logic [31:0] maxes[6];
    req_t        r;
    logic [31:0] base;

    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    no_idle = 1'b0;
    window_max = MAX_SEQ_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.insert(rows.size(), '{mk(OP_POP, 32'd5, 32'd1, 16'd1), 1'b1,
                               rs(5'b00000, '0, '0, '0, '0)});
    rows.insert(rows.size(), '{mk(OP_QUERY, 32'd0, '0, '0), 1'b1,
                               rs(5'b00000, '0, '0, '0, '0)});
    rows.insert(rows.size(), '{mk(OP_NONE, 32'hFFFF_FFFF, '1, '1), 1'b1,
                               rs(5'b00000, '0, '0, '0, '0)});
    rows.insert(rows.size(), '{mk(OP_INSERT, 32'd100, '1, 16'hFFFF), 1'b1,
                               rs(5'b01000, '0, '0, '0, 6'd1)});
    rows.insert(rows.size(), '{mk(OP_INSERT, 32'd100, '0, '0), 1'b1,
                               rs(5'b00010, '0, '0, '0, 6'd1)});
    rows.insert(rows.size(), '{mk(OP_QUERY, 32'd100, '0, '0), 1'b1,
                               rs(5'b10000, '0, '0, '0, 6'd1)});
    rows.insert(rows.size(), '{mk(OP_INSERT, 32'd50, 32'd7, 16'd7), 1'b0, '0});
    rows.insert(rows.size(), '{mk(OP_INSERT, 32'd200, 32'd8, 16'd8), 1'b0, '0});
    rows.insert(rows.size(), '{mk(OP_INSERT, 32'd150, 32'd9, 16'd9), 1'b0, '0});
    rows.insert(rows.size(), '{mk(OP_INSERT, 32'd65530, 32'd10, 16'd10), 1'b0, '0});
    rows.insert(rows.size(), '{mk(OP_INSERT, 32'hFFFF_FFFF, 32'd11, 16'd0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(OP_INSERT, 32'd0, 32'd12, 16'd12), 1'b0, '0});
    rows.insert(rows.size(), '{mk(OP_NONE, 32'd1, '0, '0), 1'b0, '0});
    for (int i = 0; i < 8; i++)
      rows.insert(rows.size(), '{mk(OP_POP, '0, '0, '0), 1'b0, '0});
    foreach (rows[i]) issue(rows[i].cmd, rows[i].typed, rows[i].want);

    // Fill past capacity for the full drop, then empty again.
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      issue(mk(OP_INSERT, 32'(i * 3), 32'(i), 16'(i)), 1'b0, '0);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) issue(mk(OP_POP, '0, '0, '0), 1'b0, '0);

    maxes = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd255, 32'd65535, 32'h8000_0000};
    foreach (maxes[m]) begin
      set_window(maxes[m]);
      base = $urandom;
      for (int n = 0; n < 250; n++) begin
        if (m == 5 && n > 200) no_idle = 1'b1;
        r = rand_req(base, maxes[m] == 0 ? 32'd64 : (maxes[m] >> 2) | 32'd15);
        if (r.op == OP_INSERT) base = base + $urandom_range(0, 8);
        issue(r, 1'b0, '0);
      end
    end
    drain();

    if (errors == 0 && pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
